// ===== rtl/core/ptc_pkg.sv =====
`timescale 1ns / 1ps
// shared widths, register codes, reset values and mac control type for the pid controller
package ptc_pkg;

    localparam int TEMP_W    = 16;
    localparam int GAIN_W    = 16;
    localparam int ERR_W     = TEMP_W + 1;
    localparam int SUM_W     = 32;
    localparam int OPND_W    = SUM_W + 1;
    localparam int PROD_W    = GAIN_W + 1 + OPND_W;
    localparam int FRAC_BITS = 8;
    localparam int ACC_W     = 43;
    localparam int DRIVE_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_STEPS = GAIN_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_TEMP = 3'd0,
        CFG_P_GAIN      = 3'd1,
        CFG_I_GAIN      = 3'd2,
        CFG_D_GAIN      = 3'd3,
        CFG_WINDUP_GAIN = 3'd4
    } cfg_index_t;

    localparam logic signed [TEMP_W-1:0] RST_TARGET_TEMP = 16'sd3232;
    localparam logic [GAIN_W-1:0]        RST_P_GAIN      = 16'd46080;
    localparam logic [GAIN_W-1:0]        RST_I_GAIN      = 16'd32;
    localparam logic [GAIN_W-1:0]        RST_D_GAIN      = 16'd8;
    localparam logic [GAIN_W-1:0]        RST_WINDUP_GAIN = 16'd0;

    // one request to the shared multiply-accumulate unit
    typedef struct packed {
        logic valid;
        logic clear;
        logic negate;
    } mac_ctl_t;

endpackage

// ===== rtl/core/pid_temperature_controller_top.sv =====
`timescale 1ns / 1ps
// pid temperature controller top level: sequencer, state and configuration registers
//
//  channel  direction  signals                          accepted when
//  s_       in         s_valid s_ready s_measured_temp  s_valid & s_ready
//  m_       out        m_valid m_ready m_drive          m_valid & m_ready
//  cfg_     in         cfg_we cfg_index cfg_wdata       cfg_we (no wait, no read-back)
//
// one request at a time: the result follows the 16-step windup-limit divider, then error sum,
// clamp and three passes of the shared multiplier
// s_ready is high only while the sequencer is idle; a new request is taken while the last
// result still waits in the output register
// a stalled result holds the sequencer before the output write, never drops data
// reset is synchronous active low: error sum and previous sample clear, gains take defaults
module pid_temperature_controller_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [ptc_pkg::TEMP_W-1:0]     s_measured_temp,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [ptc_pkg::DRIVE_W-1:0]    m_drive,
    input  logic                                  cfg_we,
    input  logic [ptc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ptc_pkg::GAIN_W-1:0]            cfg_wdata
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_SUM,
        ST_CLAMP,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_WAIT,
        ST_DONE
    } state_t;

    // configuration registers
    logic signed [ptc_pkg::TEMP_W-1:0]  target_temp_reg;
    logic [ptc_pkg::GAIN_W-1:0]         p_gain_reg;
    logic [ptc_pkg::GAIN_W-1:0]         i_gain_reg;
    logic [ptc_pkg::GAIN_W-1:0]         d_gain_reg;
    logic [ptc_pkg::GAIN_W-1:0]         windup_gain_reg;

    // sequencer and controller state
    state_t                             state_reg;
    logic signed [ptc_pkg::SUM_W-1:0]   error_sum_reg;
    logic signed [ptc_pkg::TEMP_W-1:0]  previous_temp_reg;
    logic signed [ptc_pkg::ERR_W-1:0]   err_reg;
    logic signed [ptc_pkg::ERR_W-1:0]   diff_reg;
    logic                               m_valid_reg;
    logic signed [ptc_pkg::DRIVE_W-1:0] drive_reg;

    logic                               accept;
    logic signed [ptc_pkg::ERR_W-1:0]   err_next;
    logic signed [ptc_pkg::ERR_W-1:0]   diff_next;
    logic signed [ptc_pkg::SUM_W:0]     sum_wide;
    logic signed [ptc_pkg::SUM_W-1:0]   sum_sat;
    logic signed [ptc_pkg::SUM_W-1:0]   limit;
    logic signed [ptc_pkg::SUM_W-1:0]   neg_limit;
    logic signed [ptc_pkg::SUM_W-1:0]   clamp_next;
    logic signed [ptc_pkg::DRIVE_W-1:0] drive_next;
    logic                               out_free;

    // shared unit hookup
    logic                               div_done;
    logic [ptc_pkg::GAIN_W-1:0]         div_quot;
    ptc_pkg::mac_ctl_t                  mac_ctl;
    logic [ptc_pkg::GAIN_W-1:0]         mac_gain;
    logic signed [ptc_pkg::OPND_W-1:0]  mac_operand;
    logic signed [ptc_pkg::ACC_W-1:0]   mac_acc;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // limit = floor(windup_gain / i_gain), started with every request
    ptc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .dividend (windup_gain_reg),
        .divisor  (i_gain_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // one multiplier for the p, i and d products, summed in its accumulator
    ptc_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .gain    (mac_gain),
        .operand (mac_operand),
        .acc     (mac_acc)
    );

    always_comb begin
        // error and measurement change, both 17 bit signed
        err_next  = {target_temp_reg[ptc_pkg::TEMP_W-1], target_temp_reg}
                  - {s_measured_temp[ptc_pkg::TEMP_W-1], s_measured_temp};
        diff_next = {s_measured_temp[ptc_pkg::TEMP_W-1], s_measured_temp}
                  - {previous_temp_reg[ptc_pkg::TEMP_W-1], previous_temp_reg};

        // error sum update, saturated to 32 bits
        sum_wide = {error_sum_reg[ptc_pkg::SUM_W-1], error_sum_reg}
                 + {{(ptc_pkg::SUM_W + 1 - ptc_pkg::ERR_W){err_reg[ptc_pkg::ERR_W-1]}},
                    err_reg};
        if (sum_wide[ptc_pkg::SUM_W] != sum_wide[ptc_pkg::SUM_W-1]) begin
            sum_sat = sum_wide[ptc_pkg::SUM_W]
                    ? {1'b1, {(ptc_pkg::SUM_W - 1){1'b0}}}
                    : {1'b0, {(ptc_pkg::SUM_W - 1){1'b1}}};
        end else begin
            sum_sat = sum_wide[ptc_pkg::SUM_W-1:0];
        end

        // windup clamp, skipped when integral gain is zero
        limit     = {{(ptc_pkg::SUM_W - ptc_pkg::GAIN_W){1'b0}}, div_quot};
        neg_limit = -limit;
        clamp_next = error_sum_reg;
        if (i_gain_reg != '0) begin
            if (error_sum_reg > limit) begin
                clamp_next = limit;
            end else if (error_sum_reg < neg_limit) begin
                clamp_next = neg_limit;
            end
        end

        // final saturation of p + i - d
        if (mac_acc[ptc_pkg::ACC_W-1:ptc_pkg::DRIVE_W-1] == '0
            || mac_acc[ptc_pkg::ACC_W-1:ptc_pkg::DRIVE_W-1] == '1) begin
            drive_next = mac_acc[ptc_pkg::DRIVE_W-1:0];
        end else if (mac_acc[ptc_pkg::ACC_W-1]) begin
            drive_next = {1'b1, {(ptc_pkg::DRIVE_W - 1){1'b0}}};
        end else begin
            drive_next = {1'b0, {(ptc_pkg::DRIVE_W - 1){1'b1}}};
        end
    end

    // multiplier requests: p clears the accumulator, d subtracts
    always_comb begin
        mac_ctl     = '0;
        mac_gain    = p_gain_reg;
        mac_operand = {{(ptc_pkg::OPND_W - ptc_pkg::ERR_W){err_reg[ptc_pkg::ERR_W-1]}}, err_reg};
        case (state_reg)
            ST_MUL_P: begin
                mac_ctl = '{valid: 1'b1, clear: 1'b1, negate: 1'b0};
            end
            ST_MUL_I: begin
                mac_ctl     = '{valid: 1'b1, clear: 1'b0, negate: 1'b0};
                mac_gain    = i_gain_reg;
                mac_operand = {error_sum_reg[ptc_pkg::SUM_W-1], error_sum_reg};
            end
            ST_MUL_D: begin
                mac_ctl     = '{valid: 1'b1, clear: 1'b0, negate: 1'b1};
                mac_gain    = d_gain_reg;
                mac_operand = {{(ptc_pkg::OPND_W - ptc_pkg::ERR_W){diff_reg[ptc_pkg::ERR_W-1]}},
                               diff_reg};
            end
            default: begin
                mac_ctl = '0;
            end
        endcase
    end

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_temp_reg <= ptc_pkg::RST_TARGET_TEMP;
            p_gain_reg      <= ptc_pkg::RST_P_GAIN;
            i_gain_reg      <= ptc_pkg::RST_I_GAIN;
            d_gain_reg      <= ptc_pkg::RST_D_GAIN;
            windup_gain_reg <= ptc_pkg::RST_WINDUP_GAIN;
        end else if (cfg_we) begin
            case (cfg_index)
                ptc_pkg::CFG_TARGET_TEMP: target_temp_reg <= $signed(cfg_wdata);
                ptc_pkg::CFG_P_GAIN:      p_gain_reg      <= cfg_wdata;
                ptc_pkg::CFG_I_GAIN:      i_gain_reg      <= cfg_wdata;
                ptc_pkg::CFG_D_GAIN:      d_gain_reg      <= cfg_wdata;
                ptc_pkg::CFG_WINDUP_GAIN: windup_gain_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // sequencer, controller state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            error_sum_reg     <= '0;
            previous_temp_reg <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            // the done state owns the output register while it loads it
            if (m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        err_reg           <= err_next;
                        diff_reg          <= diff_next;
                        previous_temp_reg <= s_measured_temp;
                        state_reg         <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    error_sum_reg <= sum_sat;
                    state_reg     <= ST_CLAMP;
                end
                ST_CLAMP: begin
                    error_sum_reg <= clamp_next;
                    state_reg     <= ST_MUL_P;
                end
                ST_MUL_P: state_reg <= ST_MUL_I;
                ST_MUL_I: state_reg <= ST_MUL_D;
                ST_MUL_D: state_reg <= ST_WAIT;
                ST_WAIT:  state_reg <= ST_DONE;
                ST_DONE: begin
                    // wait here while the previous result is still stalled
                    if (out_free) begin
                        drive_reg   <= drive_next;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_drive = drive_reg;

endmodule

// ===== rtl/core/ptc_div.sv =====
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle, for the windup limit
module ptc_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [ptc_pkg::GAIN_W-1:0]   dividend,
    input  logic [ptc_pkg::GAIN_W-1:0]   divisor,
    output logic                         done,
    output logic [ptc_pkg::GAIN_W-1:0]   quotient
);

    logic                           busy_reg;
    logic [ptc_pkg::DIV_CNT_W-1:0]  count_reg;
    logic [ptc_pkg::GAIN_W-1:0]     rem_reg;
    logic [ptc_pkg::GAIN_W-1:0]     dq_reg;
    logic [ptc_pkg::GAIN_W-1:0]     dvs_reg;
    logic [ptc_pkg::GAIN_W:0]       rem_shift;
    logic [ptc_pkg::GAIN_W:0]       rem_diff;
    logic                           q_bit;
    logic [ptc_pkg::GAIN_W-1:0]     rem_next;
    logic [ptc_pkg::GAIN_W-1:0]     dq_next;

    always_comb begin
        rem_shift = {rem_reg, dq_reg[ptc_pkg::GAIN_W-1]};
        rem_diff  = rem_shift - {1'b0, dvs_reg};
        q_bit     = (rem_shift >= {1'b0, dvs_reg});
        rem_next  = q_bit ? rem_diff[ptc_pkg::GAIN_W-1:0] : rem_shift[ptc_pkg::GAIN_W-1:0];
        dq_next   = {dq_reg[ptc_pkg::GAIN_W-2:0], q_bit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end else if (start) begin
            busy_reg  <= 1'b1;
            count_reg <= '0;
        end else if (busy_reg) begin
            count_reg <= count_reg + 1'b1;
            if (count_reg == ptc_pkg::DIV_CNT_W'(ptc_pkg::DIV_STEPS - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dq_reg  <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
        end
    end

    assign done     = busy_reg && (count_reg == ptc_pkg::DIV_CNT_W'(ptc_pkg::DIV_STEPS - 1));
    assign quotient = dq_reg;

endmodule

// ===== rtl/core/ptc_mac.sv =====
`timescale 1ns / 1ps
// shared multiplier with registered product and signed accumulator
module ptc_mac (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ptc_pkg::mac_ctl_t                   ctl,
    input  logic [ptc_pkg::GAIN_W-1:0]          gain,
    input  logic signed [ptc_pkg::OPND_W-1:0]   operand,
    output logic signed [ptc_pkg::ACC_W-1:0]    acc
);

    ptc_pkg::mac_ctl_t                  pend_reg;
    logic signed [ptc_pkg::PROD_W-1:0]  prod_reg;
    logic signed [ptc_pkg::PROD_W-1:0]  prod_shr;
    logic signed [ptc_pkg::ACC_W-1:0]   acc_reg;
    logic signed [ptc_pkg::ACC_W-1:0]   acc_next;
    logic signed [ptc_pkg::ACC_W-1:0]   term;
    logic signed [ptc_pkg::ACC_W-1:0]   base;

    always_comb begin
        // arithmetic shift floors toward minus infinity
        prod_shr = prod_reg >>> ptc_pkg::FRAC_BITS;
        term     = prod_shr[ptc_pkg::ACC_W-1:0];
        base     = pend_reg.clear ? '0 : acc_reg;
        acc_next = pend_reg.negate ? (base - term) : (base + term);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.valid) begin
            prod_reg <= $signed({1'b0, gain}) * operand;
        end
        if (pend_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ===== rtl/core/ptc_checker.sv =====
`timescale 1ns / 1ps
// port-level checker for the pid controller and its bind to the top level
module ptc_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic signed [ptc_pkg::DRIVE_W-1:0]    m_drive
);

    // no result survives a reset
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_drive))
        else $error("stalled result changed");

    // a request keeps the block busy: s_ready stays low after it is taken
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready ##1 !s_ready)
        else $error("request taken too soon after previous one");

    // a result never shows right after a request with the output empty
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result appeared one cycle after request");

endmodule

bind pid_temperature_controller_top ptc_checker u_ptc_checker (.*);
